// ===== design/lattice_aggregation_engine_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the lattice aggregation engine
// Shared property wrappers, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef LATTICE_AGGREGATION_ENGINE_DEFINES_SVH
`define LATTICE_AGGREGATION_ENGINE_DEFINES_SVH

// Check a property at every clock edge outside reset.
`define LA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define LA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/lae_pkg.sv =====
// ----------------------------------------------------------------------------
// lae_pkg
// Constants, codes and controller/datapath interface types of the engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lae_pkg;

	localparam int MAX_WALKERS = 1024;
	localparam int GRID_W      = 128;
	localparam int GRID_H      = 128;
	localparam int SLOT_W      = $clog2(MAX_WALKERS);
	localparam int CNT_W       = SLOT_W + 1;
	localparam int COL_W       = 7;
	localparam int ROW_W       = 7;
	localparam int CFG_W       = 8;
	localparam int CFG_IDX_W   = 1;
	localparam int IN_DATA_W   = 32;
	localparam int OUT_DATA_W  = 40;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

	typedef enum logic [2:0] {
		CMD_CLEAR      = 3'd0,
		CMD_ADD_WALKER = 3'd1,
		CMD_ADD_SEED   = 3'd2,
		CMD_PASS       = 3'd3,
		CMD_MOVE       = 3'd4
	} cmd_t;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_BAD  = 2'd2;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_ADD,
		ST_SEED_RD,
		ST_SEED_WR,
		ST_P1_RD,
		ST_P1_ROW,
		ST_P1_MARK,
		ST_P2_RD,
		ST_P2_CHK,
		ST_P2_WR,
		ST_MV_RD,
		ST_MV_WR,
		ST_EMIT
	} state_t;

	typedef enum logic [4:0] {
		DP_NOP,
		DP_CAPTURE,
		DP_CLR_ROW,
		DP_ADD,
		DP_SEED_RD,
		DP_SEED_WR,
		DP_P1_RD,
		DP_P1_ROW,
		DP_P1_MARK,
		DP_P2_RD,
		DP_P2_MAP_RD,
		DP_P2_WR,
		DP_P2_SKIP,
		DP_MV_RD,
		DP_MV_WR,
		DP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} la_cmd_t;

	typedef struct packed {
		logic fill_zero;
		logic ptr_last;
		logic k_last;
		logic clr_last;
		logic stick;
	} la_stat_t;

endpackage

`default_nettype wire

// ===== design/lae_dpath.sv =====
// ----------------------------------------------------------------------------
// lae_dpath
// Walker slot memory, stick marks, aggregate row memory and counters.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lattice_aggregation_engine_defines.svh"

module lae_dpath (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire [lae_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire [lae_pkg::CFG_W-1:0]           cfg_wdata,
	input  wire [lae_pkg::IN_DATA_W-1:0]       s_tdata,
	input  lae_pkg::la_cmd_t                   ctl,
	output lae_pkg::la_stat_t                  stat,
	output logic [lae_pkg::OUT_DATA_W-1:0]     m_tdata
);

	localparam int WORD_W = lae_pkg::COL_W + lae_pkg::ROW_W + 1;

	function automatic logic [6:0] clamp_pos(input logic signed [8:0] v,
			input logic [7:0] lim);
		logic signed [8:0] hi;
		hi = $signed({1'b0, lim}) - 9'sd1;
		if (v < 9'sd0)
			return 7'd0;
		else if (v > hi)
			return hi[6:0];
		else
			return v[6:0];
	endfunction

	function automatic logic signed [8:0] step_val(input logic [1:0] raw);
		if (raw == 2'b01)
			return 9'sd1;
		else if (raw == 2'b00)
			return 9'sd0;
		else
			return -9'sd1;
	endfunction

	logic [lae_pkg::CFG_W-1:0] grid_width_q, grid_height_q;
	logic [7:0] w_eff, h_eff;

	logic [lae_pkg::COL_W-1:0]  px_q, py_q;
	logic [lae_pkg::SLOT_W-1:0] idx_q;
	logic [1:0]                 sx_q, sy_q;

	logic [lae_pkg::CNT_W-1:0] fill_q, live_q, stuck_q, ptr_q;
	logic [1:0]                k_q;
	logic [lae_pkg::ROW_W-1:0] clr_row_q;
	logic                      acc_q;
	logic                      eval_s1, rowok_s1;
	logic [1:0]                dy_s1;

	logic [1:0]                status_q;
	logic [lae_pkg::COL_W-1:0] wx_q;
	logic [lae_pkg::ROW_W-1:0] wy_q;
	logic                      wlive_q;
	logic [lae_pkg::OUT_DATA_W-1:0] m_tdata_q;

	logic [WORD_W-1:0]           wmem [lae_pkg::MAX_WALKERS];
	logic                        smem [lae_pkg::MAX_WALKERS];
	logic [lae_pkg::GRID_W-1:0]  mmem [lae_pkg::GRID_H];
	logic [WORD_W-1:0]           wd_q;
	logic                        sd_q;
	logic [lae_pkg::GRID_W-1:0]  md_q;

	logic [lae_pkg::COL_W-1:0] wd_x;
	logic [lae_pkg::ROW_W-1:0] wd_y;
	logic                      wd_v;

	logic [6:0] add_cx, add_cy, mv_cx, mv_cy, p2_cx, p2_cy;
	logic signed [8:0] yy;
	logic       rowok, hit_now, mv_ok, full, ptr_last;

	logic                        wm_we, wm_re;
	logic [lae_pkg::SLOT_W-1:0]  wm_addr;
	logic [WORD_W-1:0]           wm_wdata;
	logic                        sm_we, sm_re, sm_wdata;
	logic                        mm_we, mm_re;
	logic [lae_pkg::ROW_W-1:0]   mm_addr;
	logic [lae_pkg::GRID_W-1:0]  mm_wdata;

	assign w_eff = (grid_width_q == 8'd0) ? 8'd1 :
		(grid_width_q > 8'(lae_pkg::GRID_W)) ? 8'(lae_pkg::GRID_W) : grid_width_q;
	assign h_eff = (grid_height_q == 8'd0) ? 8'd1 :
		(grid_height_q > 8'(lae_pkg::GRID_H)) ? 8'(lae_pkg::GRID_H) : grid_height_q;

	assign wd_x = wd_q[lae_pkg::COL_W-1:0];
	assign wd_y = wd_q[lae_pkg::COL_W +: lae_pkg::ROW_W];
	assign wd_v = wd_q[WORD_W-1];

	assign add_cx = clamp_pos($signed({2'b00, px_q}), w_eff);
	assign add_cy = clamp_pos($signed({2'b00, py_q}), h_eff);
	assign mv_cx  = clamp_pos($signed({2'b00, wd_x}) + step_val(sx_q), w_eff);
	assign mv_cy  = clamp_pos($signed({2'b00, wd_y}) + step_val(sy_q), h_eff);
	assign p2_cx  = clamp_pos($signed({2'b00, wd_x}), w_eff);
	assign p2_cy  = clamp_pos($signed({2'b00, wd_y}), h_eff);

	assign yy    = $signed({2'b00, wd_y}) + $signed({7'd0, k_q}) - 9'sd1;
	assign rowok = (yy >= 9'sd0) && (yy < $signed({1'b0, h_eff}));

	assign full     = (fill_q == lae_pkg::CNT_W'(lae_pkg::MAX_WALKERS));
	assign mv_ok    = ({1'b0, idx_q} < fill_q) && wd_v;
	assign ptr_last = ((ptr_q + lae_pkg::CNT_W'(1)) == fill_q);

	// neighbour test on the row that arrived from the map this cycle
	always_comb begin
		logic signed [8:0] xx;
		logic any;
		any = 1'b0;
		for (int dx = 0; dx < 3; dx++) begin
			xx = $signed({2'b00, wd_x}) + 9'(dx) - 9'sd1;
			if (!(dx == 1 && dy_s1 == 2'd1) && xx >= 9'sd0 &&
					xx < $signed({1'b0, w_eff}) && md_q[xx[6:0]])
				any = 1'b1;
		end
		hit_now = eval_s1 && rowok_s1 && any;
	end

	always_comb begin
		wm_we    = 1'b0;
		wm_re    = 1'b0;
		wm_addr  = ptr_q[lae_pkg::SLOT_W-1:0];
		wm_wdata = {1'b1, mv_cy, mv_cx};
		sm_we    = 1'b0;
		sm_re    = 1'b0;
		sm_wdata = wd_v && (acc_q || hit_now);
		mm_we    = 1'b0;
		mm_re    = 1'b0;
		mm_addr  = clr_row_q;
		mm_wdata = '0;
		case (ctl.op)
			lae_pkg::DP_CLR_ROW: begin
				mm_we = 1'b1;
			end
			lae_pkg::DP_ADD: begin
				wm_we    = !full;
				wm_addr  = fill_q[lae_pkg::SLOT_W-1:0];
				wm_wdata = {1'b1, add_cy, add_cx};
			end
			lae_pkg::DP_SEED_RD: begin
				mm_re   = 1'b1;
				mm_addr = add_cy;
			end
			lae_pkg::DP_SEED_WR: begin
				mm_we    = 1'b1;
				mm_addr  = add_cy;
				mm_wdata = md_q | (lae_pkg::GRID_W'(1) << add_cx);
			end
			lae_pkg::DP_P1_RD: begin
				wm_re = 1'b1;
			end
			lae_pkg::DP_P1_ROW: begin
				mm_re   = 1'b1;
				mm_addr = yy[6:0];
			end
			lae_pkg::DP_P1_MARK: begin
				sm_we = 1'b1;
			end
			lae_pkg::DP_P2_RD: begin
				wm_re = 1'b1;
				sm_re = 1'b1;
			end
			lae_pkg::DP_P2_MAP_RD: begin
				mm_re   = 1'b1;
				mm_addr = p2_cy;
			end
			lae_pkg::DP_P2_WR: begin
				mm_we    = 1'b1;
				mm_addr  = p2_cy;
				mm_wdata = md_q | (lae_pkg::GRID_W'(1) << p2_cx);
				wm_we    = 1'b1;
				wm_wdata = {1'b0, wd_q[WORD_W-2:0]};
			end
			lae_pkg::DP_MV_RD: begin
				wm_re   = 1'b1;
				wm_addr = idx_q;
			end
			lae_pkg::DP_MV_WR: begin
				wm_we   = mv_ok;
				wm_addr = idx_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wm_we)
			wmem[wm_addr] <= wm_wdata;
		if (wm_re)
			wd_q <= wmem[wm_addr];
	end

	always_ff @(posedge clk) begin
		if (sm_we)
			smem[ptr_q[lae_pkg::SLOT_W-1:0]] <= sm_wdata;
		if (sm_re)
			sd_q <= smem[ptr_q[lae_pkg::SLOT_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (mm_we)
			mmem[mm_addr] <= mm_wdata;
		if (mm_re)
			md_q <= mmem[mm_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= 8'd128;
			grid_height_q <= 8'd128;
		end else if (cfg_we) begin
			if (cfg_index == lae_pkg::REG_GRID_WIDTH)
				grid_width_q <= cfg_wdata;
			if (cfg_index == lae_pkg::REG_GRID_HEIGHT)
				grid_height_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			live_q    <= '0;
			stuck_q   <= '0;
			ptr_q     <= '0;
			k_q       <= '0;
			clr_row_q <= '0;
			acc_q     <= 1'b0;
			eval_s1   <= 1'b0;
		end else begin
			eval_s1 <= (ctl.op == lae_pkg::DP_P1_ROW);
			case (ctl.op)
				lae_pkg::DP_CAPTURE: begin
					stuck_q   <= '0;
					ptr_q     <= '0;
					clr_row_q <= '0;
				end
				lae_pkg::DP_CLR_ROW: begin
					clr_row_q <= clr_row_q + lae_pkg::ROW_W'(1);
					fill_q    <= '0;
					live_q    <= '0;
				end
				lae_pkg::DP_ADD: begin
					if (!full) begin
						fill_q <= fill_q + lae_pkg::CNT_W'(1);
						live_q <= live_q + lae_pkg::CNT_W'(1);
					end
				end
				lae_pkg::DP_P1_RD: begin
					k_q   <= '0;
					acc_q <= 1'b0;
				end
				lae_pkg::DP_P1_ROW: begin
					k_q   <= k_q + 2'd1;
					acc_q <= acc_q || hit_now;
				end
				lae_pkg::DP_P1_MARK: begin
					ptr_q <= ptr_last ? '0 : ptr_q + lae_pkg::CNT_W'(1);
				end
				lae_pkg::DP_P2_SKIP: begin
					ptr_q <= ptr_q + lae_pkg::CNT_W'(1);
				end
				lae_pkg::DP_P2_WR: begin
					ptr_q   <= ptr_q + lae_pkg::CNT_W'(1);
					live_q  <= live_q - lae_pkg::CNT_W'(1);
					stuck_q <= stuck_q + lae_pkg::CNT_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		dy_s1    <= k_q;
		rowok_s1 <= rowok;
		case (ctl.op)
			lae_pkg::DP_CAPTURE: begin
				px_q     <= s_tdata[6:0];
				py_q     <= s_tdata[13:7];
				idx_q    <= s_tdata[23:14];
				sx_q     <= s_tdata[25:24];
				sy_q     <= s_tdata[27:26];
				status_q <= lae_pkg::STAT_OK;
				wx_q     <= '0;
				wy_q     <= '0;
				wlive_q  <= 1'b0;
			end
			lae_pkg::DP_ADD: begin
				if (full) begin
					status_q <= lae_pkg::STAT_FULL;
				end else begin
					wx_q    <= add_cx;
					wy_q    <= add_cy;
					wlive_q <= 1'b1;
				end
			end
			lae_pkg::DP_MV_WR: begin
				if (mv_ok) begin
					wx_q    <= mv_cx;
					wy_q    <= mv_cy;
					wlive_q <= 1'b1;
				end else begin
					status_q <= lae_pkg::STAT_BAD;
				end
			end
			lae_pkg::DP_EMIT: begin
				m_tdata_q <= {1'b0, live_q, stuck_q, wlive_q, wy_q, wx_q, status_q};
			end
			default: begin
			end
		endcase
	end

	assign m_tdata = m_tdata_q;

	assign stat.fill_zero = (fill_q == '0);
	assign stat.ptr_last  = ptr_last;
	assign stat.k_last    = (k_q == 2'd2);
	assign stat.clr_last  = (clr_row_q == lae_pkg::ROW_W'(lae_pkg::GRID_H - 1));
	assign stat.stick     = sd_q;

	`LA_ASSERT(a_live_le_fill, live_q <= fill_q, "free walkers exceed used slots")
	`LA_ASSERT(a_stuck_le_fill, stuck_q <= fill_q, "stuck count exceeds used slots")
	`LA_ASSERT_NEXT(a_eval_follows_row, ctl.op == lae_pkg::DP_P1_ROW, eval_s1,
		"row evaluation lost after map read")

endmodule

`default_nettype wire

// ===== design/lae_ctrl.sv =====
// ----------------------------------------------------------------------------
// lae_ctrl
// Command sequencer: decodes requests and steps the datapath through them.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lattice_aggregation_engine_defines.svh"

module lae_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	output logic                 s_tready,
	input  wire [2:0]            s_tuser,
	output logic                 m_tvalid,
	input  wire                  m_tready,
	input  lae_pkg::la_stat_t    stat,
	output lae_pkg::la_cmd_t     ctl
);

	lae_pkg::state_t state_q, state_d;
	logic            m_tvalid_q;
	logic            out_free;

	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= lae_pkg::ST_INIT;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.op == lae_pkg::DP_EMIT)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl.op   = lae_pkg::DP_NOP;
		s_tready = 1'b0;
		unique case (state_q)
			lae_pkg::ST_INIT: begin
				ctl.op = lae_pkg::DP_CLR_ROW;
				if (stat.clr_last)
					state_d = lae_pkg::ST_IDLE;
			end
			lae_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					ctl.op = lae_pkg::DP_CAPTURE;
					unique case (s_tuser)
						lae_pkg::CMD_CLEAR:      state_d = lae_pkg::ST_CLEAR;
						lae_pkg::CMD_ADD_WALKER: state_d = lae_pkg::ST_ADD;
						lae_pkg::CMD_ADD_SEED:   state_d = lae_pkg::ST_SEED_RD;
						lae_pkg::CMD_PASS:
							state_d = stat.fill_zero ? lae_pkg::ST_EMIT : lae_pkg::ST_P1_RD;
						lae_pkg::CMD_MOVE:       state_d = lae_pkg::ST_MV_RD;
						default:                 state_d = lae_pkg::ST_EMIT;
					endcase
				end
			end
			lae_pkg::ST_CLEAR: begin
				ctl.op = lae_pkg::DP_CLR_ROW;
				if (stat.clr_last)
					state_d = lae_pkg::ST_EMIT;
			end
			lae_pkg::ST_ADD: begin
				ctl.op  = lae_pkg::DP_ADD;
				state_d = lae_pkg::ST_EMIT;
			end
			lae_pkg::ST_SEED_RD: begin
				ctl.op  = lae_pkg::DP_SEED_RD;
				state_d = lae_pkg::ST_SEED_WR;
			end
			lae_pkg::ST_SEED_WR: begin
				ctl.op  = lae_pkg::DP_SEED_WR;
				state_d = lae_pkg::ST_EMIT;
			end
			lae_pkg::ST_P1_RD: begin
				ctl.op  = lae_pkg::DP_P1_RD;
				state_d = lae_pkg::ST_P1_ROW;
			end
			lae_pkg::ST_P1_ROW: begin
				ctl.op = lae_pkg::DP_P1_ROW;
				if (stat.k_last)
					state_d = lae_pkg::ST_P1_MARK;
			end
			lae_pkg::ST_P1_MARK: begin
				ctl.op  = lae_pkg::DP_P1_MARK;
				state_d = stat.ptr_last ? lae_pkg::ST_P2_RD : lae_pkg::ST_P1_RD;
			end
			lae_pkg::ST_P2_RD: begin
				ctl.op  = lae_pkg::DP_P2_RD;
				state_d = lae_pkg::ST_P2_CHK;
			end
			lae_pkg::ST_P2_CHK: begin
				if (stat.stick) begin
					ctl.op  = lae_pkg::DP_P2_MAP_RD;
					state_d = lae_pkg::ST_P2_WR;
				end else begin
					ctl.op  = lae_pkg::DP_P2_SKIP;
					state_d = stat.ptr_last ? lae_pkg::ST_EMIT : lae_pkg::ST_P2_RD;
				end
			end
			lae_pkg::ST_P2_WR: begin
				ctl.op  = lae_pkg::DP_P2_WR;
				state_d = stat.ptr_last ? lae_pkg::ST_EMIT : lae_pkg::ST_P2_RD;
			end
			lae_pkg::ST_MV_RD: begin
				ctl.op  = lae_pkg::DP_MV_RD;
				state_d = lae_pkg::ST_MV_WR;
			end
			lae_pkg::ST_MV_WR: begin
				ctl.op  = lae_pkg::DP_MV_WR;
				state_d = lae_pkg::ST_EMIT;
			end
			lae_pkg::ST_EMIT: begin
				if (out_free) begin
					ctl.op  = lae_pkg::DP_EMIT;
					state_d = lae_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lae_pkg::ST_IDLE;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;

	`LA_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready,
		"request accepted while another is in flight")
	`LA_ASSERT(a_emit_free, (ctl.op == lae_pkg::DP_EMIT) |-> (!m_tvalid || m_tready),
		"result overwrites one not yet taken")
	`LA_ASSERT_NEXT(a_emit_shows, ctl.op == lae_pkg::DP_EMIT, m_tvalid,
		"loaded result not presented")

endmodule

`default_nettype wire

// ===== design/lattice_aggregation_engine.sv =====
// ----------------------------------------------------------------------------
// lattice_aggregation_engine
// 2D diffusion-limited aggregation lattice: walker pool plus aggregate bitmap.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: command; tdata: position, slot, steps
// m_*       out  m_tvalid/m_tready  tdata: status, walker position, counts
// cfg_*     in   cfg_we             cfg_index selects grid_width / grid_height
//
// One request at a time. Unknown commands load the result directly; add walker
// writes a slot; add seed and move read, then write, a map row or a slot.
// Clear sweeps the 128-row aggregate memory one row a cycle.
// An aggregation pass first scans each used slot against its neighbour rows
// (one map row read per neighbour row) and marks it, then updates each slot,
// with a map write for a slot that sticks; a pass over an empty pool loads its
// result directly. The next request is accepted in the cycle after the result
// is loaded. After reset the same row sweep clears the map before the first
// request is accepted; write configuration only while no request is in flight.
// A pending result holds in the output register while the next request is
// accepted; the sequencer stalls only when a new result is ready to load.
//
`default_nettype none

module lattice_aggregation_engine (
	input  wire                              clk,
	input  wire                              arst_n,
	// config write port
	input  wire                              cfg_we,
	input  wire [lae_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire [lae_pkg::CFG_W-1:0]         cfg_wdata,
	// request stream
	input  wire                              s_tvalid,
	output logic                             s_tready,
	// pos_x[6:0], pos_y[13:7], walker_index[23:14], step_x[25:24],
	// step_y[27:26], zero [31:28]
	input  wire [lae_pkg::IN_DATA_W-1:0]     s_tdata,
	// command[2:0]
	input  wire [2:0]                        s_tuser,
	// result stream
	output logic                             m_tvalid,
	input  wire                              m_tready,
	// status[1:0], walker_x[8:2], walker_y[15:9], walker_live[16],
	// stuck_count[27:17], walker_count[38:28], zero [39]
	output logic [lae_pkg::OUT_DATA_W-1:0]   m_tdata
);

	lae_pkg::la_cmd_t  ctl;
	lae_pkg::la_stat_t stat;

	// sequencer: owns handshakes; one datapath op per cycle unless the output stalls
	lae_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.ctl      (ctl)
	);

	// datapath: slot memory, stick marks, aggregate rows, counters, result
	lae_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.ctl       (ctl),
		.stat      (stat),
		.m_tdata   (m_tdata)
	);

endmodule

`default_nettype wire
